FILE: rtl/core/hbm_pkg.sv
// ----------------------------------------------------------------------------
// hbm_pkg: heartbeat health monitor shared definitions
// Transaction types, item and fault codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package hbm_pkg;

   // number of supervised tasks and the width of a task index
   localparam int TASKS  = 8;
   localparam int TASK_W = $clog2(TASKS);

   // item kinds
   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_STACK = 2'd1;
   localparam logic [1:0] MODE_EVAL  = 2'd2;

   // health event kinds
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_ALIVE      = 3'd1;
   localparam logic [2:0] EV_QUEUE_FULL = 3'd2;
   localparam logic [2:0] EV_RX_TIMEOUT = 3'd3;
   localparam logic [2:0] EV_TX_TIMEOUT = 3'd4;
   localparam logic [2:0] EV_INTERNAL   = 3'd5;

   // fault reasons
   localparam logic [2:0] RSN_QUEUE    = 3'd0;
   localparam logic [2:0] RSN_RX       = 3'd1;
   localparam logic [2:0] RSN_TX       = 3'd2;
   localparam logic [2:0] RSN_INTERNAL = 3'd3;
   localparam logic [2:0] RSN_STALLED  = 3'd4;
   localparam logic [2:0] RSN_STACK    = 3'd5;

   // error classes
   localparam logic [1:0] ERR_BUSY     = 2'd0;
   localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
   localparam logic [1:0] ERR_INTERNAL = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_REQUIRED  = 3'd0;
   localparam logic [2:0] CSR_START     = 3'd1;
   localparam logic [2:0] CSR_GRACE     = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_STACK_MIN = 3'd4;

   // input transaction
   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  task_index;
      logic [2:0]  event_kind;
      logic [31:0] time_ms;
      logic [31:0] event_detail;
      logic [31:0] stack_words;
   } req_type;

   // result transaction
   typedef struct packed {
      logic        fault_valid;
      logic [2:0]  fault_reason;
      logic [2:0]  fault_task;
      logic [31:0] fault_time_ms;
      logic [31:0] fault_detail;
      logic [1:0]  error_kind;
      logic        blocks_watchdog;
      logic        watchdog_ok;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_GRACE,
      ST_READ,
      ST_STALL,
      ST_STACK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/task_heartbeat_health_monitor.sv
// ----------------------------------------------------------------------------
// task_heartbeat_health_monitor: per-task heartbeat supervisor
// Records heartbeats and stack watermarks, raises one-shot faults and scans
// the required tasks for stalls and low stacks with one shared unit.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start and not busy
//  result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//  config    csr_we, csr_index, csr_wdata   written when csr_we is high
//
// An item keeps busy high through apply, grace check and finish, plus a
// read step for each task that is not required and a memory read, stall
// check and stack check for each required task scanned. The scan stops at
// the first newly reported fault or, for items other than evaluate, at the
// first failing watchdog check. The single subtract-compare unit and the one
// read port of the time and watermark memories set this sequence. The result
// strobe comes in the cycle after finish; reset clears all control and latched flags.
// ----------------------------------------------------------------------------
module task_heartbeat_health_monitor
   import hbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [7:0]  required_ff;
   logic [31:0] start_time_ff;
   logic [31:0] grace_ff;
   logic [31:0] timeout_ff;
   logic [31:0] stack_min_ff;

   // sequencer and item registers
   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [TASK_W-1:0] idx_ff, idx_in;
   logic              wd_ff, wd_in;
   rsp_type           fault_ff, fault_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // supervision state
   logic             crit_ff, crit_in;
   logic [TASKS-1:0] seen_ff, seen_in;
   logic [TASKS-1:0] known_ff, known_in;
   logic [TASKS-1:0] stall_rep_ff, stall_rep_in;
   logic [TASKS-1:0] low_rep_ff, low_rep_in;
   logic [3:0]       ftl_ff [TASKS];
   logic [3:0]       ftl_in [TASKS];

   // heartbeat time and watermark memories
   logic [31:0] hb_mem   [TASKS];
   logic [31:0] mark_mem [TASKS];
   logic [31:0] hb_rd_ff;
   logic [31:0] mark_rd_ff;
   logic        hb_we;
   logic        mark_we;

   // shared unit operands
   logic [31:0] op_a, op_b, limit, diff;
   logic        below;

   logic accept;
   logic is_eval;
   logic last_task;
   logic stall;
   logic low;
   logic [1:0] kbit;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_eval   = (req_ff.mode == MODE_EVAL);
   assign last_task = (idx_ff == TASK_W'(TASKS - 1));
   assign kbit      = 2'(req_ff.event_kind - EV_QUEUE_FULL);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff   <= '0;
         start_time_ff <= '0;
         grace_ff      <= '0;
         timeout_ff    <= '0;
         stack_min_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REQUIRED:  required_ff   <= csr_wdata[7:0];
            CSR_START:     start_time_ff <= csr_wdata;
            CSR_GRACE:     grace_ff      <= csr_wdata;
            CSR_TIMEOUT:   timeout_ff    <= csr_wdata;
            CSR_STACK_MIN: stack_min_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand selection for the shared unit
   always_comb begin
      op_a  = req_ff.time_ms;
      op_b  = start_time_ff;
      limit = grace_ff;
      unique case (state_ff)
         ST_STALL: begin
            op_b  = seen_ff[idx_ff] ? hb_rd_ff : start_time_ff;
            limit = timeout_ff;
         end
         ST_STACK: begin
            op_a  = mark_rd_ff;
            op_b  = '0;
            limit = stack_min_ff;
         end
         default: ;
      endcase
   end

   hbm_sub_cmp u_unit (
      .op_a  (op_a),
      .op_b  (op_b),
      .limit (limit),
      .diff  (diff),
      .below (below)
   );

   assign stall = !seen_ff[idx_ff] || !below;
   assign low   = known_ff[idx_ff] && below;

   // next state and state updates
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wd_in        = wd_ff;
      fault_in     = fault_ff;
      crit_in      = crit_ff;
      seen_in      = seen_ff;
      known_in     = known_ff;
      stall_rep_in = stall_rep_ff;
      low_rep_in   = low_rep_ff;
      ftl_in       = ftl_ff;
      hb_we        = 1'b0;
      mark_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fault_in = '0;
               state_in = ST_APPLY;
            end
         end

         // event and watermark updates
         ST_APPLY: begin
            state_in = ST_GRACE;
            if (req_ff.mode == MODE_EVENT) begin
               if (req_ff.event_kind == EV_ALIVE) begin
                  hb_we                      = 1'b1;
                  seen_in[req_ff.task_index] = 1'b1;
               end else if (req_ff.event_kind >= EV_QUEUE_FULL &&
                            req_ff.event_kind <= EV_INTERNAL) begin
                  if (!ftl_ff[req_ff.task_index][kbit]) begin
                     ftl_in[req_ff.task_index][kbit] = 1'b1;
                     fault_in.fault_valid   = 1'b1;
                     fault_in.fault_reason  = {1'b0, kbit};
                     fault_in.fault_task    = req_ff.task_index;
                     fault_in.fault_time_ms = req_ff.time_ms;
                     fault_in.fault_detail  = req_ff.event_detail;
                     if (req_ff.event_kind == EV_INTERNAL) begin
                        crit_in                  = 1'b1;
                        fault_in.error_kind      = ERR_INTERNAL;
                        fault_in.blocks_watchdog = 1'b1;
                     end else if (req_ff.event_kind == EV_QUEUE_FULL) begin
                        fault_in.error_kind = ERR_BUSY;
                     end else begin
                        fault_in.error_kind = ERR_TIMEOUT;
                     end
                  end
               end
            end else if (req_ff.mode == MODE_STACK) begin
               mark_we                     = 1'b1;
               known_in[req_ff.task_index] = 1'b1;
            end
         end

         // startup grace check
         ST_GRACE: begin
            idx_in = '0;
            wd_in  = 1'b1;
            if (is_eval) begin
               state_in = below ? ST_DONE : ST_READ;
            end else if (crit_ff) begin
               wd_in    = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = below ? ST_DONE : ST_READ;
            end
         end

         // skip tasks that are not required, else wait for memory data
         ST_READ: begin
            if (required_ff[idx_ff]) begin
               state_in = ST_STALL;
            end else if (last_task) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // heartbeat age check
         ST_STALL: begin
            state_in = ST_STACK;
            if (stall) begin
               if (is_eval) begin
                  crit_in = 1'b1;
                  if (!stall_rep_ff[idx_ff]) begin
                     stall_rep_in[idx_ff]     = 1'b1;
                     fault_in.fault_valid     = 1'b1;
                     fault_in.fault_reason    = RSN_STALLED;
                     fault_in.fault_task      = 3'(idx_ff);
                     fault_in.fault_time_ms   = req_ff.time_ms;
                     fault_in.fault_detail    = diff;
                     fault_in.error_kind      = ERR_INTERNAL;
                     fault_in.blocks_watchdog = 1'b1;
                     state_in                 = ST_DONE;
                  end
               end else begin
                  wd_in    = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end

         // stack watermark check, then on to the next task
         ST_STACK: begin
            state_in = last_task ? ST_DONE : ST_READ;
            idx_in   = idx_ff + 1'b1;
            if (low) begin
               if (is_eval) begin
                  crit_in = 1'b1;
                  if (!low_rep_ff[idx_ff]) begin
                     low_rep_in[idx_ff]       = 1'b1;
                     fault_in.fault_valid     = 1'b1;
                     fault_in.fault_reason    = RSN_STACK;
                     fault_in.fault_task      = 3'(idx_ff);
                     fault_in.fault_time_ms   = req_ff.time_ms;
                     fault_in.fault_detail    = mark_rd_ff;
                     fault_in.error_kind      = ERR_INTERNAL;
                     fault_in.blocks_watchdog = 1'b1;
                     state_in                 = ST_DONE;
                  end
               end else begin
                  wd_in    = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end

         // present the result transaction
         ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in             = fault_ff;
            rsp_in.watchdog_ok = is_eval ? !crit_ff : wd_ff;
            state_in           = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and latched flags
   always_ff @(posedge clock) begin
      if (reset) begin
         crit_ff      <= 1'b0;
         seen_ff      <= '0;
         known_ff     <= '0;
         stall_rep_ff <= '0;
         low_rep_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         wd_ff        <= 1'b0;
         for (int i = 0; i < TASKS; i++) begin
            ftl_ff[i] <= '0;
         end
      end else begin
         crit_ff      <= crit_in;
         seen_ff      <= seen_in;
         known_ff     <= known_in;
         stall_rep_ff <= stall_rep_in;
         low_rep_ff   <= low_rep_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         wd_ff        <= wd_in;
         ftl_ff       <= ftl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      fault_ff <= fault_in;
      rsp_ff   <= rsp_in;
   end

   // memories: one write port at the item's task, one registered read at the scan index
   always_ff @(posedge clock) begin
      if (hb_we) begin
         hb_mem[req_ff.task_index] <= req_ff.time_ms;
      end
      if (mark_we) begin
         mark_mem[req_ff.task_index] <= req_ff.stack_words;
      end
      hb_rd_ff   <= hb_mem[idx_ff];
      mark_rd_ff <= mark_mem[idx_ff];
   end

endmodule

FILE: rtl/core/hbm_sub_cmp.sv
// ----------------------------------------------------------------------------
// hbm_sub_cmp: shared subtract and compare unit
// Forms the wrapped difference a - b and flags it when below the limit.
// ----------------------------------------------------------------------------
module hbm_sub_cmp
   import hbm_pkg::*;
(
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] limit,
   output logic [31:0] diff,
   output logic        below
);

   // modulo 2^32 difference, then unsigned compare
   assign diff  = op_a - op_b;
   assign below = diff < limit;

endmodule

FILE: rtl/core/hbm_checker.sv
// ----------------------------------------------------------------------------
// hbm_checker: port-level checks for the heartbeat health monitor
// Watches the command, result and status ports over time.
// ----------------------------------------------------------------------------
module hbm_checker
   import hbm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input rsp_type     rsp_data
);

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // the result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a result only follows a transaction in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   // empty fault record when no fault is reported
   a_no_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.fault_valid) |->
         (rsp_data.fault_reason == 3'd0 && rsp_data.fault_task == 3'd0 &&
          rsp_data.fault_time_ms == 32'd0 && rsp_data.fault_detail == 32'd0 &&
          rsp_data.error_kind == 2'd0 && !rsp_data.blocks_watchdog))
      else $error("fault fields set without a fault");

   // a blocking fault withholds the watchdog refresh
   a_block_wd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fault_valid && rsp_data.blocks_watchdog) |->
         !rsp_data.watchdog_ok)
      else $error("blocking fault reported with watchdog ok");

endmodule

bind task_heartbeat_health_monitor hbm_checker u_hbm_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb: heartbeat health monitor testbench
// Drives a short table of directed transactions, split around phases of random
// heartbeat, stack and evaluate traffic under several register settings.
// Every result is checked against its table entry or a shadow copy of the supervisor state.
// ----------------------------------------------------------------------------
module tb;
   import hbm_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [2:0] EV_RSVD6   = 3'd6;
   localparam logic [2:0] EV_RSVD7   = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_data  = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = CSR_REQUIRED;
   logic [31:0] csr_wdata = '0;

   task_heartbeat_health_monitor DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers
   logic [7:0]  cfg_required  = '0;
   logic [31:0] cfg_start     = '0;
   logic [31:0] cfg_grace     = '0;
   logic [31:0] cfg_timeout   = '0;
   logic [31:0] cfg_stack_min = '0;

   // shadow supervisor state
   logic [31:0] beat_time   [TASKS];
   logic [7:0]  beat_seen   = '0;
   logic [3:0]  fault_once  [TASKS];
   logic [7:0]  stall_done  = '0;
   logic [7:0]  stack_done  = '0;
   logic [31:0] stack_level [TASKS];
   logic [7:0]  level_known = '0;
   logic        critical    = 1'b0;

   rsp_type     owed_reports [$];
   int          mismatches   = 0;
   logic [31:0] clk_ms       = '0;

   // directed table
   req_type     plan_req   [$];
   rsp_type     plan_rsp   [$];
   bit          plan_typed [$];

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic in_grace(input logic [31:0] now);
      logic [31:0] since;
      since = now - cfg_start;
      return since < cfg_grace;
   endfunction

   function automatic logic stack_short(input int t);
      return level_known[t] && (stack_level[t] < cfg_stack_min);
   endfunction

   function automatic logic watchdog_clear(input logic [31:0] now);
      logic [31:0] age;
      if (critical) return 1'b0;
      if (in_grace(now)) return 1'b1;
      for (int t = 0; t < TASKS; t++) begin
         if (cfg_required[t]) begin
            if (!beat_seen[t]) return 1'b0;
            age = now - beat_time[t];
            if (age >= cfg_timeout || stack_short(t)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic rsp_type fault_rec(input logic [2:0] reason, input logic [2:0] tsk,
                                         input logic [31:0] tm, input logic [31:0] det,
                                         input logic [1:0] err, input logic blk,
                                         input logic ok);
      rsp_type f;
      f.fault_valid     = 1'b1;
      f.fault_reason    = reason;
      f.fault_task      = tsk;
      f.fault_time_ms   = tm;
      f.fault_detail    = det;
      f.error_kind      = err;
      f.blocks_watchdog = blk;
      f.watchdog_ok     = ok;
      return f;
   endfunction

   function automatic rsp_type no_fault(input logic ok);
      rsp_type f;
      f = '0;
      f.watchdog_ok = ok;
      return f;
   endfunction

   // advance the shadow state by one transaction and return its report
   function automatic rsp_type health_verdict(input req_type r);
      rsp_type     out;
      logic [3:0]  once;
      logic [31:0] age;
      logic        done;
      out  = '0;
      done = 1'b0;
      case (r.mode)
         MODE_EVENT: begin
            if (r.event_kind == EV_ALIVE) begin
               beat_time[r.task_index] = r.time_ms;
               beat_seen[r.task_index] = 1'b1;
            end else if (r.event_kind >= EV_QUEUE_FULL && r.event_kind <= EV_INTERNAL) begin
               // each fault type is raised once per task
               once = 4'b0001 << (r.event_kind - EV_QUEUE_FULL);
               if ((fault_once[r.task_index] & once) == '0) begin
                  fault_once[r.task_index] |= once;
                  case (r.event_kind)
                     EV_QUEUE_FULL: out = fault_rec(RSN_QUEUE, r.task_index, r.time_ms,
                                                    r.event_detail, ERR_BUSY, 1'b0, 1'b0);
                     EV_RX_TIMEOUT: out = fault_rec(RSN_RX, r.task_index, r.time_ms,
                                                    r.event_detail, ERR_TIMEOUT, 1'b0, 1'b0);
                     EV_TX_TIMEOUT: out = fault_rec(RSN_TX, r.task_index, r.time_ms,
                                                    r.event_detail, ERR_TIMEOUT, 1'b0, 1'b0);
                     default: begin
                        out = fault_rec(RSN_INTERNAL, r.task_index, r.time_ms,
                                        r.event_detail, ERR_INTERNAL, 1'b1, 1'b0);
                        critical = 1'b1;
                     end
                  endcase
               end
            end
         end
         MODE_STACK: begin
            stack_level[r.task_index] = r.stack_words;
            level_known[r.task_index] = 1'b1;
         end
         MODE_EVAL: begin
            // scan required tasks, report the first new stall or low stack
            if (!in_grace(r.time_ms)) begin
               for (int t = 0; t < TASKS; t++) begin
                  if (!done && cfg_required[t]) begin
                     age = beat_seen[t] ? r.time_ms - beat_time[t] : r.time_ms - cfg_start;
                     if (!beat_seen[t] || age >= cfg_timeout) begin
                        critical = 1'b1;
                        if (!stall_done[t]) begin
                           stall_done[t] = 1'b1;
                           out = fault_rec(RSN_STALLED, 3'(t), r.time_ms, age, ERR_INTERNAL,
                                           1'b1, 1'b0);
                           done = 1'b1;
                        end
                     end
                     if (!done && stack_short(t)) begin
                        critical = 1'b1;
                        if (!stack_done[t]) begin
                           stack_done[t] = 1'b1;
                           out = fault_rec(RSN_STACK, 3'(t), r.time_ms, stack_level[t],
                                           ERR_INTERNAL, 1'b1, 1'b0);
                           done = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      out.watchdog_ok = watchdog_clear(r.time_ms);
      return out;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void complain(input string why, input rsp_type want,
                                    input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: want v%0d rsn%0d tsk%0d t=%h d=%h err%0d blk%0d ok%0d",
                  $time, why, want.fault_valid, want.fault_reason, want.fault_task,
                  want.fault_time_ms, want.fault_detail, want.error_kind,
                  want.blocks_watchdog, want.watchdog_ok);
         $display("   got v%0d rsn%0d tsk%0d t=%h d=%h err%0d blk%0d ok%0d",
                  got.fault_valid, got.fault_reason, got.fault_task, got.fault_time_ms,
                  got.fault_detail, got.error_kind, got.blocks_watchdog, got.watchdog_ok);
      end
   endfunction

   // compare each result transaction with the oldest owed report
   always @(posedge clock) begin : score
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (owed_reports.size() == 0) begin
            complain("result with nothing owed", '0, rsp_data);
         end else begin
            want = owed_reports.pop_front();
            if (rsp_data.fault_valid !== want.fault_valid ||
                rsp_data.fault_reason !== want.fault_reason ||
                rsp_data.fault_task !== want.fault_task ||
                rsp_data.fault_time_ms !== want.fault_time_ms ||
                rsp_data.fault_detail !== want.fault_detail ||
                rsp_data.error_kind !== want.error_kind ||
                rsp_data.blocks_watchdog !== want.blocks_watchdog ||
                rsp_data.watchdog_ok !== want.watchdog_ok)
               complain("mismatch", want, rsp_data);
         end
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type verdict;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      verdict = health_verdict(r);
      owed_reports.push_back(typed ? typed_rsp : verdict);
   endtask

   // sender idles: short gaps mostly, a few long ones, quiet stretches without any
   task automatic pace(input int i);
      int          gap;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if ((i % 100) < 25 || roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(20, 120);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed report has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (owed_reports.size() != 0 || busy);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] need, input logic [31:0] t0,
                            input logic [31:0] grace, input logic [31:0] tmo,
                            input logic [31:0] smin);
      drain();
      write_reg(CSR_REQUIRED, {24'd0, need});
      write_reg(CSR_START, t0);
      write_reg(CSR_GRACE, grace);
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_STACK_MIN, smin);
      cfg_required  = need;
      cfg_start     = t0;
      cfg_grace     = grace;
      cfg_timeout   = tmo;
      cfg_stack_min = smin;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic req_type mk_req(input logic [1:0] m, input logic [2:0] tsk,
                                      input logic [2:0] k, input logic [31:0] tm,
                                      input logic [31:0] det, input logic [31:0] words);
      req_type r;
      r.mode         = m;
      r.task_index   = tsk;
      r.event_kind   = k;
      r.time_ms      = tm;
      r.event_detail = det;
      r.stack_words  = words;
      return r;
   endfunction

   function automatic void plan_add(input req_type r, input bit typed, input rsp_type e);
      plan_req.push_back(r);
      plan_typed.push_back(typed);
      plan_rsp.push_back(e);
   endfunction

   // random transaction around a slowly advancing clock; without hazard nothing
   // can latch the critical flag, so the watchdog terms stay observable
   function automatic req_type pick_item(input bit hazard);
      req_type     r;
      int unsigned roll;
      r.task_index   = 3'($urandom_range(0, 7));
      r.event_detail = $urandom;
      r.stack_words  = $urandom;
      clk_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 25);
      r.time_ms = ($urandom_range(0, 9) == 0) ? $urandom : clk_ms;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         r.mode       = MODE_EVENT;
         r.event_kind = EV_ALIVE;
      end else if (roll < 55) begin
         r.mode       = MODE_EVENT;
         r.event_kind = 3'($urandom_range(EV_QUEUE_FULL,
                                          hazard ? EV_INTERNAL : EV_TX_TIMEOUT));
      end else if (roll < 60) begin
         r.mode = MODE_EVENT;
         case ($urandom_range(0, 2))
            0:       r.event_kind = EV_NONE;
            1:       r.event_kind = EV_RSVD6;
            default: r.event_kind = EV_RSVD7;
         endcase
      end else if (roll < 78) begin
         r.mode       = MODE_STACK;
         r.event_kind = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 3) != 0)
            r.stack_words = cfg_stack_min + $urandom_range(0, 40) - 20;
      end else if (roll < 95) begin
         r.mode       = MODE_EVAL;
         r.event_kind = 3'($urandom_range(0, 7));
         if (!hazard)
            r.time_ms = cfg_start + $urandom_range(0, cfg_grace - 1);
      end else begin
         r.mode       = MODE_SPARE;
         r.event_kind = 3'($urandom_range(0, 7));
      end
      return r;
   endfunction

   task automatic run_plan(input int lo, input int hi);
      for (int i = lo; i < hi; i++) begin
         send(plan_req[i], plan_typed[i], plan_rsp[i]);
         pace(i + 30);
      end
   endtask

   task automatic run_random(input int count, input bit hazard);
      clk_ms = cfg_start;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0)
            drain();
         send(pick_item(hazard), 1'b0, '0);
         pace(i);
      end
   endtask

   initial begin : stimulus
      for (int t = 0; t < TASKS; t++)
         fault_once[t] = '0;

      // after reset: one-shot event faults, ignored kinds, watermark extremes
      plan_add(mk_req(MODE_EVAL, 3'd0, EV_NONE, 32'h0, 32'h0, 32'h0), 1'b1, no_fault(1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd7, EV_QUEUE_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF), 1'b1,
               fault_rec(RSN_QUEUE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ERR_BUSY, 1'b0, 1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd7, EV_QUEUE_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF), 1'b1, no_fault(1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd0, EV_RX_TIMEOUT, 32'h0, 32'h0, 32'h0), 1'b1,
               fault_rec(RSN_RX, 3'd0, 32'h0, 32'h0, ERR_TIMEOUT, 1'b0, 1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd3, EV_TX_TIMEOUT, 32'h8000_0000, 32'h5555_AAAA,
                      32'h0), 1'b1,
               fault_rec(RSN_TX, 3'd3, 32'h8000_0000, 32'h5555_AAAA, ERR_TIMEOUT, 1'b0,
                         1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd2, EV_NONE, 32'h1, 32'h1, 32'h0), 1'b1, no_fault(1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd5, EV_RSVD6, 32'h1234, 32'h0, 32'h0), 1'b1,
               no_fault(1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd6, EV_RSVD7, 32'h1235, 32'h0, 32'h0), 1'b1,
               no_fault(1'b1));
      plan_add(mk_req(MODE_SPARE, 3'd7, EV_RSVD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF), 1'b1, no_fault(1'b1));
      plan_add(mk_req(MODE_STACK, 3'd1, EV_NONE, 32'h2, 32'h0, 32'hFFFF_FFFF), 1'b1,
               no_fault(1'b1));
      plan_add(mk_req(MODE_STACK, 3'd0, EV_NONE, 32'h3, 32'h0, 32'h0), 1'b1, no_fault(1'b1));
      plan_add(mk_req(MODE_EVENT, 3'd0, EV_ALIVE, 32'd100, 32'h0, 32'h0), 1'b1,
               no_fault(1'b1));
      // grace window that wraps past zero, then a stale heartbeat and a low stack
      plan_add(mk_req(MODE_EVENT, 3'd1, EV_ALIVE, 32'h50, 32'h0, 32'h0), 1'b0, '0);
      plan_add(mk_req(MODE_EVAL, 3'd0, EV_NONE, 32'hFF, 32'h0, 32'h0), 1'b0, '0);
      plan_add(mk_req(MODE_EVENT, 3'd0, EV_ALIVE, 32'hF0, 32'h0, 32'h0), 1'b0, '0);
      plan_add(mk_req(MODE_EVENT, 3'd0, EV_NONE, 32'h100, 32'h0, 32'h0), 1'b0, '0);
      plan_add(mk_req(MODE_STACK, 3'd0, EV_NONE, 32'h100, 32'h0, 32'd10), 1'b0, '0);
      // stall and stack-low reports, then the internal error
      repeat (5)
         plan_add(mk_req(MODE_EVAL, 3'd0, EV_NONE, 32'hFFFF_FFFF, 32'h0, 32'h0), 1'b0, '0);
      plan_add(mk_req(MODE_EVENT, 3'd4, EV_INTERNAL, 32'd77, 32'hDEAD_BEEF, 32'h0), 1'b1,
               fault_rec(RSN_INTERNAL, 3'd4, 32'd77, 32'hDEAD_BEEF, ERR_INTERNAL, 1'b1,
                         1'b0));
      plan_add(mk_req(MODE_EVENT, 3'd4, EV_INTERNAL, 32'd78, 32'h0, 32'h0), 1'b1,
               no_fault(1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_plan(0, 12);
      configure(8'h03, 32'hFFFF_FF00, 32'h0000_0200, 32'd50, 32'd10);
      run_plan(12, 17);

      // random traffic that keeps the critical flag clear
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: configure(8'hFF, 32'hFFFF_FFF0, 32'h0000_0100, 32'd200, 32'h0000_0400);
            1: configure(8'($urandom), $urandom, $urandom_range(1, 5000),
                         $urandom_range(1, 600), $urandom_range(0, 65535));
            2: configure(8'h00, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            default: configure(8'($urandom), $urandom, $urandom_range(1, 2000),
                               $urandom_range(30, 300), $urandom_range(0, 3000));
         endcase
         run_random(190, 1'b0);
      end

      configure(8'hFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_plan(17, plan_req.size());

      // random traffic with stalls, low stacks and internal errors
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: configure(8'h0F, $urandom, $urandom_range(0, 500), $urandom_range(30, 300),
                         $urandom_range(0, 2000));
            1: configure(8'hF0, 32'h0, 32'h0, 32'h0, 32'h0);
            default: configure(8'hFF, $urandom, $urandom_range(0, 100), $urandom, $urandom);
         endcase
         run_random(165, 1'b1);
      end

      // wind down
      start <= 1'b0;
      for (int n = 0; n < 5000 && owed_reports.size() != 0; n++)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && owed_reports.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
